// ===== design/cpu_load_monitor_unit_assert.svh =====
// ----------------------------------------------------------------------------
// cpu_load_monitor_unit_assert.svh
// Assertion macros shared by the load monitor RTL.
// ----------------------------------------------------------------------------
`ifndef CPU_LOAD_MONITOR_UNIT_ASSERT_SVH
`define CPU_LOAD_MONITOR_UNIT_ASSERT_SVH

// same-cycle implication
`define CLM_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("load monitor: same-cycle check failed");

// next-cycle implication
`define CLM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("load monitor: next-cycle check failed");

`endif

// ===== design/clm_pkg.sv =====
// ----------------------------------------------------------------------------
// clm_pkg
// Types and constants of the CPU load monitor.
// ----------------------------------------------------------------------------
`default_nettype none

package clm_pkg;

   localparam int DATA_W     = 32;
   localparam int TICK_W     = 32;
   localparam int ACTION_W   = 2;
   localparam int INTERVAL_W = 16;
   localparam int LOAD_W     = 10;
   localparam int HIST_DEPTH = 8;
   localparam int SCALE_W    = DATA_W + LOAD_W;
   localparam int DIV_CNT_W  = $clog2(LOAD_W);

   localparam logic [LOAD_W-1:0]     LOAD_FULL      = LOAD_W'(1000);
   localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = INTERVAL_W'(1000);

   localparam logic [ACTION_W-1:0] ACT_IDLE_ENTER = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_IDLE_EXIT  = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_SAMPLE     = 2'd2;

   typedef enum logic [1:0] {
      PAIR_INSTANT,
      PAIR_SECOND,
      PAIR_FIVE
   } pair_type;

   typedef struct packed {
      logic                capture;
      logic                apply;
      logic [ACTION_W-1:0] action;
      logic [DATA_W-1:0]   cycle_count;
      logic [TICK_W-1:0]   tick_ms;
   } hist_cmd_type;

   typedef struct packed {
      logic              start;
      logic [DATA_W-1:0] td;
      logic [DATA_W-1:0] id;
   } div_req_type;

   typedef struct packed {
      logic              done;
      logic [LOAD_W-1:0] load;
   } div_rsp_type;

endpackage

`default_nettype wire

// ===== design/clm_if.sv =====
// ----------------------------------------------------------------------------
// clm_if
// Valid/ready channels of the load monitor: event beats in, load beats out.
// ----------------------------------------------------------------------------
`default_nettype none

interface clm_req_if;
   logic                          valid;
   logic                          ready;
   logic [clm_pkg::ACTION_W-1:0]  action;
   logic [clm_pkg::DATA_W-1:0]    cycle_count;
   logic [clm_pkg::TICK_W-1:0]    tick_ms;

   modport source (output valid, action, cycle_count, tick_ms, input ready);
   modport sink   (input valid, action, cycle_count, tick_ms, output ready);
endinterface

interface clm_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [clm_pkg::LOAD_W-1:0]  load_instant;
   logic [clm_pkg::LOAD_W-1:0]  load_last_second;
   logic [clm_pkg::LOAD_W-1:0]  load_five_seconds;
   logic                        idle_now;

   modport source (output valid, load_instant, load_last_second, load_five_seconds,
                   idle_now, input ready);
   modport sink   (input valid, load_instant, load_last_second, load_five_seconds,
                   idle_now, output ready);
endinterface

`default_nettype wire

// ===== design/clm_history.sv =====
// ----------------------------------------------------------------------------
// clm_history
// Idle accounting and the eight-slot snapshot history; delta of a slot pair.
// ----------------------------------------------------------------------------
`default_nettype none

`include "cpu_load_monitor_unit_assert.svh"

module clm_history (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic [clm_pkg::INTERVAL_W-1:0]    interval,
   input  wire clm_pkg::hist_cmd_type             cmd,
   input  wire clm_pkg::pair_type                 pair,
   output logic [clm_pkg::DATA_W-1:0]             td,
   output logic [clm_pkg::DATA_W-1:0]             id,
   output logic                                   idle_flag
);

   logic                           idle_flag_ff;
   logic [clm_pkg::DATA_W-1:0]     idle_start_ff;
   logic [clm_pkg::DATA_W-1:0]     idle_sum_ff;
   logic [clm_pkg::TICK_W-1:0]     last_shift_ff;
   logic [clm_pkg::DATA_W-1:0]     hist_total_ff [clm_pkg::HIST_DEPTH];
   logic [clm_pkg::DATA_W-1:0]     hist_idle_ff  [clm_pkg::HIST_DEPTH];

   logic [clm_pkg::ACTION_W-1:0]   action_ff;
   logic [clm_pkg::DATA_W-1:0]     cycles_ff;
   logic [clm_pkg::TICK_W-1:0]     tick_ff;
   logic [clm_pkg::DATA_W-1:0]     idle_len_ff;
   logic [clm_pkg::TICK_W-1:0]     tick_gap_ff;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         action_ff   <= cmd.action;
         cycles_ff   <= cmd.cycle_count;
         tick_ff     <= cmd.tick_ms;
         idle_len_ff <= cmd.cycle_count - idle_start_ff;
         tick_gap_ff <= cmd.tick_ms - last_shift_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idle_flag_ff  <= 1'b0;
         idle_start_ff <= '0;
         idle_sum_ff   <= '0;
         last_shift_ff <= '0;
         for (int i = 0; i < clm_pkg::HIST_DEPTH; i++) begin
            hist_total_ff[i] <= '0;
            hist_idle_ff[i]  <= '0;
         end
      end else if (cmd.apply) begin
         case (action_ff)
            clm_pkg::ACT_IDLE_ENTER: begin
               if (!idle_flag_ff) begin
                  idle_start_ff <= cycles_ff;
                  idle_flag_ff  <= 1'b1;
               end
            end
            clm_pkg::ACT_IDLE_EXIT: begin
               if (idle_flag_ff) begin
                  idle_sum_ff  <= idle_sum_ff + idle_len_ff;
                  idle_flag_ff <= 1'b0;
               end
            end
            clm_pkg::ACT_SAMPLE: begin
               hist_total_ff[1] <= hist_total_ff[0];
               hist_idle_ff[1]  <= hist_idle_ff[0];
               hist_total_ff[0] <= cycles_ff;
               hist_idle_ff[0]  <= idle_sum_ff;
               if (tick_gap_ff >= clm_pkg::TICK_W'(interval)) begin
                  last_shift_ff <= tick_ff;
                  for (int i = 3; i < clm_pkg::HIST_DEPTH; i++) begin
                     hist_total_ff[i] <= hist_total_ff[i-1];
                     hist_idle_ff[i]  <= hist_idle_ff[i-1];
                  end
                  hist_total_ff[2] <= hist_total_ff[0];
                  hist_idle_ff[2]  <= hist_idle_ff[0];
               end
            end
            default: ;
         endcase
      end
   end

   always_comb begin
      case (pair)
         clm_pkg::PAIR_INSTANT: begin
            td = hist_total_ff[0] - hist_total_ff[1];
            id = hist_idle_ff[0]  - hist_idle_ff[1];
         end
         clm_pkg::PAIR_SECOND: begin
            td = hist_total_ff[2] - hist_total_ff[3];
            id = hist_idle_ff[2]  - hist_idle_ff[3];
         end
         default: begin
            td = hist_total_ff[2] - hist_total_ff[clm_pkg::HIST_DEPTH-1];
            id = hist_idle_ff[2]  - hist_idle_ff[clm_pkg::HIST_DEPTH-1];
         end
      endcase
   end

   assign idle_flag = idle_flag_ff;

   `CLM_ASSERT_IMPLIES(a_apply_after_capture, clock, reset, cmd.apply, $past(cmd.capture))

endmodule

`default_nettype wire

// ===== design/clm_divider.sv =====
// ----------------------------------------------------------------------------
// clm_divider
// Bit-serial load unit: 1000 - floor(1000*id/td), 0 if td = 0 or id > td; one quotient bit a cycle.
// ----------------------------------------------------------------------------
`default_nettype none

`include "cpu_load_monitor_unit_assert.svh"

module clm_divider (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire clm_pkg::div_req_type  req,
   output clm_pkg::div_rsp_type       rsp
);

   typedef enum logic [2:0] {
      D_IDLE,
      D_SCALE1,
      D_SCALE2,
      D_SHIFT,
      D_FINISH
   } dstate_type;

   dstate_type                        state_ff;
   logic [clm_pkg::DATA_W-1:0]        td_ff;
   logic [clm_pkg::DATA_W-1:0]        id_ff;
   logic                              zero_ff;
   logic [clm_pkg::SCALE_W-1:0]       acc_ff;
   logic [clm_pkg::DATA_W-1:0]        rem_ff;
   logic [clm_pkg::LOAD_W-1:0]        quo_ff;
   logic [clm_pkg::DIV_CNT_W-1:0]     count_ff;
   logic                              done_ff;
   logic [clm_pkg::LOAD_W-1:0]        load_ff;

   logic [clm_pkg::SCALE_W-1:0]       scaled_in;
   logic [clm_pkg::DATA_W:0]          trial_in;
   logic                              fits_in;

   // 1000*id = 1024*id - 16*id - 8*id
   assign scaled_in = acc_ff - (clm_pkg::SCALE_W'(id_ff) << 3);
   assign trial_in  = {rem_ff, quo_ff[clm_pkg::LOAD_W-1]};
   assign fits_in   = trial_in >= {1'b0, td_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= D_IDLE;
         done_ff  <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         unique case (state_ff)
            D_IDLE: begin
               if (req.start) begin
                  td_ff    <= req.td;
                  id_ff    <= req.id;
                  zero_ff  <= (req.td == '0) || (req.id > req.td);
                  state_ff <= D_SCALE1;
               end
            end
            D_SCALE1: begin
               acc_ff   <= (clm_pkg::SCALE_W'(id_ff) << clm_pkg::LOAD_W)
                           - (clm_pkg::SCALE_W'(id_ff) << 4);
               state_ff <= D_SCALE2;
            end
            D_SCALE2: begin
               rem_ff   <= scaled_in[clm_pkg::SCALE_W-1:clm_pkg::LOAD_W];
               quo_ff   <= scaled_in[clm_pkg::LOAD_W-1:0];
               count_ff <= '0;
               state_ff <= D_SHIFT;
            end
            D_SHIFT: begin
               rem_ff   <= clm_pkg::DATA_W'(fits_in ? trial_in - {1'b0, td_ff} : trial_in);
               quo_ff   <= {quo_ff[clm_pkg::LOAD_W-2:0], fits_in};
               count_ff <= count_ff + 1'b1;
               if (count_ff == clm_pkg::DIV_CNT_W'(clm_pkg::LOAD_W - 1)) begin
                  state_ff <= D_FINISH;
               end
            end
            D_FINISH: begin
               load_ff  <= zero_ff ? '0 : clm_pkg::LOAD_FULL - quo_ff;
               done_ff  <= 1'b1;
               state_ff <= D_IDLE;
            end
            default: state_ff <= D_IDLE;
         endcase
      end
   end

   assign rsp.done = done_ff;
   assign rsp.load = load_ff;

   `CLM_ASSERT_IMPLIES(a_start_when_free, clock, reset, req.start, state_ff == D_IDLE)
   `CLM_ASSERT_IMPLIES(a_load_in_range, clock, reset, done_ff, load_ff <= clm_pkg::LOAD_FULL)

endmodule

`default_nettype wire

// ===== design/cpu_load_monitor_unit.sv =====
// An event beat (idle enter, idle exit or sample) passes these steps from
// acceptance to its load beat: the apply step records the idle start, adds to
// the idle sum or shifts the history, then the three loads pass one after
// another through a shared bit-serial divider (a start step, two scaling steps,
// ten quotient bits, a finish step and a handoff), and the output register is
// loaded once the sink has taken any previous beat. A new event is accepted in
// the cycle after the previous result reaches the output register, so the
// unit takes no new event while one is still in flight.
// ----------------------------------------------------------------------------
// cpu_load_monitor_unit
// CPU load from idle time: instant, one-second and five-second loads in
// tenths of a percent for every event beat.
// ----------------------------------------------------------------------------
`default_nettype none

`include "cpu_load_monitor_unit_assert.svh"

module cpu_load_monitor_unit (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             csr_write_enable,
   input  wire logic [clm_pkg::INTERVAL_W-1:0]   csr_write_data,
   clm_req_if.sink                               req_ch,
   clm_rsp_if.source                             rsp_ch
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_APPLY,
      S_START,
      S_WAIT,
      S_OUT
   } state_type;

   state_type                          state_ff;
   clm_pkg::pair_type                  pair_ff;
   logic [clm_pkg::INTERVAL_W-1:0]     interval_ff;
   logic [clm_pkg::LOAD_W-1:0]         inst_ff;
   logic [clm_pkg::LOAD_W-1:0]         second_ff;
   logic [clm_pkg::LOAD_W-1:0]         five_ff;
   logic                               rsp_valid_ff;
   logic [clm_pkg::LOAD_W-1:0]         rsp_inst_ff;
   logic [clm_pkg::LOAD_W-1:0]         rsp_second_ff;
   logic [clm_pkg::LOAD_W-1:0]         rsp_five_ff;
   logic                               rsp_idle_ff;

   logic                               req_fire;
   logic                               rsp_fire;
   clm_pkg::hist_cmd_type              hist_cmd;
   clm_pkg::div_req_type               div_req;
   clm_pkg::div_rsp_type               div_rsp;
   logic [clm_pkg::DATA_W-1:0]         pair_td;
   logic [clm_pkg::DATA_W-1:0]         pair_id;
   logic                               idle_flag;

   assign req_ch.ready = (state_ff == S_IDLE);
   assign req_fire     = req_ch.valid && req_ch.ready;
   assign rsp_fire     = rsp_valid_ff && rsp_ch.ready;

   assign hist_cmd.capture     = req_fire;
   assign hist_cmd.apply       = (state_ff == S_APPLY);
   assign hist_cmd.action      = req_ch.action;
   assign hist_cmd.cycle_count = req_ch.cycle_count;
   assign hist_cmd.tick_ms     = req_ch.tick_ms;

   assign div_req.start = (state_ff == S_START);
   assign div_req.td    = pair_td;
   assign div_req.id    = pair_id;

   always_ff @(posedge clock) begin
      if (reset) begin
         interval_ff <= clm_pkg::INTERVAL_RESET;
      end else if (csr_write_enable) begin
         interval_ff <= csr_write_data;
      end
   end

   clm_history u_history (
      .clock     (clock),
      .reset     (reset),
      .interval  (interval_ff),
      .cmd       (hist_cmd),
      .pair      (pair_ff),
      .td        (pair_td),
      .id        (pair_id),
      .idle_flag (idle_flag)
   );

   clm_divider u_divider (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         pair_ff      <= clm_pkg::PAIR_INSTANT;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_fire && (state_ff != S_OUT)) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_fire) begin
                  state_ff <= S_APPLY;
               end
            end
            S_APPLY: begin
               pair_ff  <= clm_pkg::PAIR_INSTANT;
               state_ff <= S_START;
            end
            S_START: begin
               state_ff <= S_WAIT;
            end
            S_WAIT: begin
               if (div_rsp.done) begin
                  case (pair_ff)
                     clm_pkg::PAIR_INSTANT: begin
                        inst_ff  <= div_rsp.load;
                        pair_ff  <= clm_pkg::PAIR_SECOND;
                        state_ff <= S_START;
                     end
                     clm_pkg::PAIR_SECOND: begin
                        second_ff <= div_rsp.load;
                        pair_ff   <= clm_pkg::PAIR_FIVE;
                        state_ff  <= S_START;
                     end
                     default: begin
                        five_ff  <= div_rsp.load;
                        state_ff <= S_OUT;
                     end
                  endcase
               end
            end
            S_OUT: begin
               if (!rsp_valid_ff || rsp_ch.ready) begin
                  rsp_inst_ff   <= inst_ff;
                  rsp_second_ff <= second_ff;
                  rsp_five_ff   <= five_ff;
                  rsp_idle_ff   <= idle_flag;
                  rsp_valid_ff  <= 1'b1;
                  state_ff      <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_ch.valid             = rsp_valid_ff;
   assign rsp_ch.load_instant      = rsp_inst_ff;
   assign rsp_ch.load_last_second  = rsp_second_ff;
   assign rsp_ch.load_five_seconds = rsp_five_ff;
   assign rsp_ch.idle_now          = rsp_idle_ff;

   `CLM_ASSERT_IMPLIES(a_done_while_waiting, clock, reset, div_rsp.done, state_ff == S_WAIT)
   `CLM_ASSERT_NEXT(a_accept_then_apply, clock, reset, req_fire, state_ff == S_APPLY)

endmodule

`default_nettype wire
